[rtl/core/trimmed_mean_zone_classifier_defines.svh]
// assertion macros for the trimmed mean zone classifier checker
// no dependencies; included by the checker file
`ifndef TRIMMED_MEAN_ZONE_CLASSIFIER_DEFINES_SVH
`define TRIMMED_MEAN_ZONE_CLASSIFIER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TMZC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmzc same-cycle check failed");

// next-cycle implication, disabled during reset
`define TMZC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmzc next-cycle check failed");

`endif

[rtl/core/tmzc_pkg.sv]
// shared types and constants for the trimmed mean zone classifier
// no dependencies
`default_nettype none

package tmzc_pkg;

    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 16;
    localparam int MIN_W    = 13;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 2;
    localparam int ZONE_W   = 2;

    localparam logic [MIN_W-1:0] MIN_START = 13'd4096;

    localparam logic [CFG_IDX_W-1:0] REG_ZONE_FLOOR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_EDGE_ONE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_EDGE_TWO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_CEILING  = 2'd3;

    localparam logic [CFG_W-1:0] ZONE_FLOOR_RST    = 12'd0;
    localparam logic [CFG_W-1:0] ZONE_EDGE_ONE_RST = 12'd1000;
    localparam logic [CFG_W-1:0] ZONE_EDGE_TWO_RST = 12'd2200;
    localparam logic [CFG_W-1:0] ZONE_CEILING_RST  = 12'd4095;

    localparam logic [ZONE_W-1:0] ZONE_LOW  = 2'd0;
    localparam logic [ZONE_W-1:0] ZONE_MID  = 2'd1;
    localparam logic [ZONE_W-1:0] ZONE_HIGH = 2'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                axis;
    } item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mean_value;
        logic [ZONE_W-1:0]   zone;
        logic                axis_out;
    } result_t;

    typedef struct packed {
        logic [SUM_W-1:0]    sum;
        logic [SAMPLE_W-1:0] largest;
        logic [SAMPLE_W-1:0] smallest;
        logic                axis;
    } burst_totals_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mean_value;
        logic                axis;
    } mean_t;

endpackage

`default_nettype wire

[rtl/core/tmzc_accum.sv]
// burst accumulator: drops the settling sample, sums and tracks extremes
// depends on tmzc_pkg
`default_nettype none

module tmzc_accum #(
    parameter int SAMPLES = 6
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   adv,
    input  wire logic                   item_valid,
    input  wire tmzc_pkg::item_t        item,
    output logic                        totals_valid,
    output tmzc_pkg::burst_totals_t     totals
);
    import tmzc_pkg::*;

    localparam int CNT_W = $clog2(SAMPLES + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES);

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SAMPLE_W-1:0] max_reg, max_next;
    logic [MIN_W-1:0]    min_reg, min_next;
    logic                totals_valid_reg, totals_valid_next;
    burst_totals_t       totals_reg, totals_next;

    logic                accept;
    logic [SUM_W-1:0]    sum_upd;
    logic [SAMPLE_W-1:0] max_upd;
    logic [MIN_W-1:0]    min_upd;
    logic [MIN_W-1:0]    sample_wide;

    assign accept      = item_valid && adv;
    assign sample_wide = {1'b0, item.sample};
    assign sum_upd     = sum_reg + SUM_W'(item.sample);
    assign max_upd     = (item.sample >= max_reg) ? item.sample : max_reg;
    assign min_upd     = (sample_wide <= min_reg) ? sample_wide : min_reg;

    always_comb
    begin
        count_next        = count_reg;
        sum_next          = sum_reg;
        max_next          = max_reg;
        min_next          = min_reg;
        totals_valid_next = totals_valid_reg;
        totals_next       = totals_reg;
        if (adv)
        begin
            totals_valid_next = 1'b0;
        end
        if (accept)
        begin
            if (count_reg == '0)
            begin
                count_next = CNT_W'(1);
            end
            else if (count_reg != LAST_CNT)
            begin
                count_next = count_reg + CNT_W'(1);
                sum_next   = sum_upd;
                max_next   = max_upd;
                min_next   = min_upd;
            end
            else
            begin
                totals_valid_next    = 1'b1;
                totals_next.sum      = sum_upd;
                totals_next.largest  = max_upd;
                totals_next.smallest = min_upd[SAMPLE_W-1:0];
                totals_next.axis     = item.axis;
                count_next           = '0;
                sum_next             = '0;
                max_next             = '0;
                min_next             = MIN_START;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            sum_reg          <= '0;
            max_reg          <= '0;
            min_reg          <= MIN_START;
            totals_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            sum_reg          <= sum_next;
            max_reg          <= max_next;
            min_reg          <= min_next;
            totals_valid_reg <= totals_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        totals_reg <= totals_next;
    end

    assign totals_valid = totals_valid_reg;
    assign totals       = totals_reg;

endmodule

`default_nettype wire

[rtl/core/tmzc_divide.sv]
// trims the extremes and divides by samples minus two via reciprocal multiply
// depends on tmzc_pkg
`default_nettype none

module tmzc_divide #(
    parameter int SAMPLES = 6
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       adv,
    input  wire logic                       totals_valid,
    input  wire tmzc_pkg::burst_totals_t    totals,
    output logic                            mean_valid,
    output tmzc_pkg::mean_t                 mean
);
    import tmzc_pkg::*;

    localparam int    DIVISOR    = SAMPLES - 2;
    localparam int    SHIFT      = SUM_W + $clog2(DIVISOR);
    localparam int    RECIP_W    = SUM_W + 1;
    localparam int    PROD_W     = SUM_W + RECIP_W;
    localparam longint RECIP_FULL = ((longint'(1) << SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    logic [SUM_W-1:0]  trimmed;
    logic [PROD_W-1:0] product;
    logic [PROD_W-1:0] quotient;

    logic  mean_valid_reg, mean_valid_next;
    mean_t mean_reg, mean_next;

    assign trimmed  = totals.sum - SUM_W'(totals.largest) - SUM_W'(totals.smallest);
    assign product  = PROD_W'(trimmed) * PROD_W'(RECIP);
    assign quotient = product >> SHIFT;

    always_comb
    begin
        mean_valid_next = mean_valid_reg;
        mean_next       = mean_reg;
        if (adv)
        begin
            mean_valid_next = totals_valid;
            if (totals_valid)
            begin
                mean_next.mean_value = quotient[SAMPLE_W-1:0];
                mean_next.axis       = totals.axis;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_valid_reg <= 1'b0;
        end
        else
        begin
            mean_valid_reg <= mean_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mean_reg <= mean_next;
    end

    assign mean_valid = mean_valid_reg;
    assign mean       = mean_reg;

endmodule

`default_nettype wire

[rtl/core/tmzc_classify.sv]
// zone boundary registers, zone classification and the result register
// depends on tmzc_pkg
`default_nettype none

module tmzc_classify (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               adv,
    input  wire logic                               cfg_wr_en,
    input  wire logic [tmzc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tmzc_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                               mean_valid,
    input  wire tmzc_pkg::mean_t                    mean,
    output logic                                    result_valid,
    output tmzc_pkg::result_t                       result
);
    import tmzc_pkg::*;

    logic [CFG_W-1:0] floor_reg, floor_next;
    logic [CFG_W-1:0] edge_one_reg, edge_one_next;
    logic [CFG_W-1:0] edge_two_reg, edge_two_next;
    logic [CFG_W-1:0] ceiling_reg, ceiling_next;

    logic             result_valid_reg, result_valid_next;
    result_t          result_reg, result_next;
    logic [ZONE_W-1:0] zone;

    always_comb
    begin
        floor_next    = floor_reg;
        edge_one_next = edge_one_reg;
        edge_two_next = edge_two_reg;
        ceiling_next  = ceiling_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ZONE_FLOOR:    floor_next    = cfg_data;
                REG_ZONE_EDGE_ONE: edge_one_next = cfg_data;
                REG_ZONE_EDGE_TWO: edge_two_next = cfg_data;
                REG_ZONE_CEILING:  ceiling_next  = cfg_data;
                default:           floor_next    = floor_reg;
            endcase
        end
    end

    // first matching zone wins, outside every zone falls back to the low zone
    always_comb
    begin
        if (mean.mean_value > floor_reg && mean.mean_value <= edge_one_reg)
        begin
            zone = ZONE_LOW;
        end
        else if (mean.mean_value > edge_one_reg && mean.mean_value <= edge_two_reg)
        begin
            zone = ZONE_MID;
        end
        else if (mean.mean_value > edge_two_reg && mean.mean_value <= ceiling_reg)
        begin
            zone = ZONE_HIGH;
        end
        else
        begin
            zone = ZONE_LOW;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (adv)
        begin
            result_valid_next = mean_valid;
            if (mean_valid)
            begin
                result_next.mean_value = mean.mean_value;
                result_next.zone       = zone;
                result_next.axis_out   = mean.axis;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg        <= ZONE_FLOOR_RST;
            edge_one_reg     <= ZONE_EDGE_ONE_RST;
            edge_two_reg     <= ZONE_EDGE_TWO_RST;
            ceiling_reg      <= ZONE_CEILING_RST;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            floor_reg        <= floor_next;
            edge_one_reg     <= edge_one_next;
            edge_two_reg     <= edge_two_next;
            ceiling_reg      <= ceiling_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

[rtl/core/trimmed_mean_zone_classifier.sv]
// trimmed mean zone classifier, top level
// depends on tmzc_pkg, tmzc_accum, tmzc_divide, tmzc_classify
//
// item channel: item_valid, item_stall, item (sample, axis). one item per cycle.
// the first item of each burst is a settling conversion and is dropped; the next
// SAMPLES items are summed, largest and smallest are removed and the rest is
// divided by SAMPLES-2. one result item follows each burst of SAMPLES+1 items.
// result channel: result_valid, result_stall, result (mean_value, zone, axis_out).
// the totals, the mean and the result are registered in turn after the edge that
// accepts the last item of a burst. throughput: one item per cycle, through the
// three-stage pipe (accumulator, reciprocal multiply, classify and result register).
// a stalled result holds the whole pipe: item_stall follows result_stall while a
// result is waiting. otherwise items are taken every cycle.
// config: cfg_wr_en, cfg_index, cfg_data write the four zone boundaries; write
// only while the block is idle.
// reset: burst restarts (next item dropped), boundaries return to 0, 1000, 2200,
// 4095, no result pending.
`default_nettype none

module trimmed_mean_zone_classifier #(
    parameter int SAMPLES = 6
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               item_valid,
    output logic                                    item_stall,
    input  wire tmzc_pkg::item_t                    item,
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output tmzc_pkg::result_t                       result,
    input  wire logic                               cfg_wr_en,
    input  wire logic [tmzc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tmzc_pkg::CFG_W-1:0]         cfg_data
);
    import tmzc_pkg::*;

    logic          adv;
    logic          totals_valid;
    burst_totals_t totals;
    logic          mean_valid;
    mean_t         mean;

    assign adv        = !(result_valid && result_stall);
    assign item_stall = !adv;

    tmzc_accum #(
        .SAMPLES(SAMPLES)
    ) u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .item_valid   (item_valid),
        .item         (item),
        .totals_valid (totals_valid),
        .totals       (totals)
    );

    tmzc_divide #(
        .SAMPLES(SAMPLES)
    ) u_divide (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .totals_valid (totals_valid),
        .totals       (totals),
        .mean_valid   (mean_valid),
        .mean         (mean)
    );

    tmzc_classify u_classify (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mean_valid   (mean_valid),
        .mean         (mean),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

[rtl/core/tmzc_checker.sv]
// port-level checks for the trimmed mean zone classifier, bound to the top level
// depends on tmzc_pkg and trimmed_mean_zone_classifier_defines.svh
`default_nettype none

`include "trimmed_mean_zone_classifier_defines.svh"

module tmzc_checker (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_stall,
    input  wire logic                   result_valid,
    input  wire logic                   result_stall,
    input  wire tmzc_pkg::result_t      result
);
    import tmzc_pkg::*;

    `TMZC_ASSERT_NEXT(a_result_valid_holds, clk, rst_n, result_valid && result_stall, result_valid)
    `TMZC_ASSERT_NEXT(a_result_item_holds, clk, rst_n, result_valid && result_stall, $stable(result))
    `TMZC_ASSERT_NOW(a_stall_only_on_backpressure, clk, rst_n, item_stall, result_valid && result_stall)
    `TMZC_ASSERT_NOW(a_zone_code_legal, clk, rst_n, result_valid, result.zone == ZONE_LOW || result.zone == ZONE_MID || result.zone == ZONE_HIGH)

endmodule

bind trimmed_mean_zone_classifier tmzc_checker u_tmzc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

[tb/tb.sv]
// self-checking testbench for trimmed_mean_zone_classifier: random bursts, zone settings, stalls
// depends on tmzc_pkg and the rtl top level; predicts every result item and checks it in order
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tmzc_pkg::*;

    localparam int SAMPLES_PER_BURST = 6;
    localparam int BURSTS_PER_PHASE = 8;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_CYCLES = 8;
    localparam int QUIET_LIMIT = 4000;

    typedef enum int unsigned {
        MIX_UNIFORM,
        MIX_FLAT,
        MIX_RAILS,
        MIX_NARROW,
        MIX_LOW
    } burst_shape_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    item_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    result_t result;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    item_t pending_items[$];
    result_t expected_results[$];
    result_t oldest_expected;
    int unsigned items_queued = 0;
    int unsigned items_taken = 0;
    int unsigned failures = 0;
    int unsigned idle_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_done = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;

    // predicted block state
    logic [CFG_W-1:0] zone_bound [4];
    int unsigned burst_pos = 0;
    logic [SUM_W-1:0] burst_sum = '0;
    logic [SAMPLE_W-1:0] burst_max = '0;
    logic [MIN_W-1:0] burst_min = MIN_START;

    trimmed_mean_zone_classifier #(
        .SAMPLES(SAMPLES_PER_BURST)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    task automatic track_burst(input item_t it);
        int unsigned trimmed;
        logic [SAMPLE_W-1:0] m;
        result_t r;
        if (burst_pos == 0)
        begin
            burst_pos = 1;
            return;
        end
        if (it.sample >= burst_max)
            burst_max = it.sample;
        if ({1'b0, it.sample} <= burst_min)
            burst_min = {1'b0, it.sample};
        burst_sum = burst_sum + SUM_W'(it.sample);
        if (burst_pos < SAMPLES_PER_BURST)
        begin
            burst_pos++;
            return;
        end
        trimmed = (32'(burst_sum) - 32'(burst_max) - 32'(burst_min))
                  / (SAMPLES_PER_BURST - 2);
        m = trimmed[SAMPLE_W-1:0];
        r.mean_value = m;
        if (m > zone_bound[REG_ZONE_FLOOR] && m <= zone_bound[REG_ZONE_EDGE_ONE])
            r.zone = ZONE_LOW;
        else if (m > zone_bound[REG_ZONE_EDGE_ONE] && m <= zone_bound[REG_ZONE_EDGE_TWO])
            r.zone = ZONE_MID;
        else if (m > zone_bound[REG_ZONE_EDGE_TWO] && m <= zone_bound[REG_ZONE_CEILING])
            r.zone = ZONE_HIGH;
        else
            r.zone = ZONE_LOW;
        r.axis_out = it.axis;
        expected_results.push_back(r);
        burst_pos = 0;
        burst_sum = '0;
        burst_max = '0;
        burst_min = MIN_START;
    endtask

    // item sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                track_burst(item);
                items_taken++;
            end
            if (!item_valid || !item_stall)
            begin
                if (gap_left != 0)
                begin
                    item_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
                begin
                    item_valid <= 1'b0;
                    gap_left <= $urandom_range(2);
                end
                else if (pending_items.size() != 0)
                begin
                    item_valid <= 1'b1;
                    item <= pending_items.pop_front();
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
            holds_done <= 0;
        end
        else if (hold_left != 0)
        begin
            result_stall <= 1'b1;
            hold_left <= hold_left - 1;
            if (hold_left == 1)
                holds_done <= holds_done + 1;
        end
        else if (holds_done != hold_requests)
        begin
            result_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (stall_left != 0)
        begin
            result_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            result_stall <= 1'b1;
            stall_left <= $urandom_range(2);
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                if (failures < 10)
                    $display("tb: unexpected result mean %0d zone %0d axis %0d",
                             result.mean_value, result.zone, result.axis_out);
                failures++;
            end
            else
            begin
                oldest_expected = expected_results.pop_front();
                if (result.mean_value !== oldest_expected.mean_value ||
                    result.zone !== oldest_expected.zone ||
                    result.axis_out !== oldest_expected.axis_out)
                begin
                    if (failures < 10)
                    begin
                        $write("tb: mismatch expected mean %0d zone %0d axis %0d",
                               oldest_expected.mean_value, oldest_expected.zone,
                               oldest_expected.axis_out);
                        $display(", got mean %0d zone %0d axis %0d",
                                 result.mean_value, result.zone, result.axis_out);
                    end
                    failures++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_wr_en)
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb: FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_item(input logic [SAMPLE_W-1:0] s, input logic ax);
        item_t it;
        it.sample = s;
        it.axis = ax;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic queue_burst();
        burst_shape_t shape;
        logic [SAMPLE_W-1:0] base;
        int v;
        shape = burst_shape_t'($urandom_range(4));
        base = SAMPLE_W'($urandom);
        if (shape == MIX_FLAT)
        begin
            // land the mean on or next to a zone boundary
            v = int'(zone_bound[CFG_IDX_W'($urandom_range(3))]) + int'($urandom_range(2)) - 1;
            if (v < 0)
                v = 0;
            if (v > 4095)
                v = 4095;
            base = v[SAMPLE_W-1:0];
        end
        queue_item(SAMPLE_W'($urandom), 1'($urandom));
        repeat (SAMPLES_PER_BURST)
        begin
            case (shape)
                MIX_FLAT:   queue_item(base, 1'($urandom));
                MIX_RAILS:  queue_item($urandom_range(1) != 0 ? {SAMPLE_W{1'b1}} :
                                       {SAMPLE_W{1'b0}}, 1'($urandom));
                MIX_NARROW: queue_item(base + SAMPLE_W'($urandom_range(3)), 1'($urandom));
                MIX_LOW:    queue_item(SAMPLE_W'($urandom_range(15)), 1'($urandom));
                default:    queue_item(SAMPLE_W'($urandom), 1'($urandom));
            endcase
        end
        // stray items shift the burst alignment
        if ($urandom_range(5) == 0)
            repeat ($urandom_range(1, 3))
                queue_item(SAMPLE_W'($urandom), 1'($urandom));
    endtask

    task automatic settle();
        while (items_taken != items_queued || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_bound(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        zone_bound[idx] = val;
    endtask

    task automatic set_zones(input logic [CFG_W-1:0] lo, e1, e2, hi);
        write_bound(REG_ZONE_FLOOR, lo);
        write_bound(REG_ZONE_EDGE_ONE, e1);
        write_bound(REG_ZONE_EDGE_TWO, e2);
        write_bound(REG_ZONE_CEILING, hi);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input int unsigned pct);
        idle_pct = pct;
        repeat (BURSTS_PER_PHASE) queue_burst();
    endtask

    initial
    begin
        logic [CFG_W-1:0] a;
        logic [CFG_W-1:0] b;
        logic [CFG_W-1:0] c;
        zone_bound[REG_ZONE_FLOOR] = ZONE_FLOOR_RST;
        zone_bound[REG_ZONE_EDGE_ONE] = ZONE_EDGE_ONE_RST;
        zone_bound[REG_ZONE_EDGE_TWO] = ZONE_EDGE_TWO_RST;
        zone_bound[REG_ZONE_CEILING] = ZONE_CEILING_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all zero burst after a full-scale settling sample
        queue_item(12'd4095, 1'b1);
        repeat (SAMPLES_PER_BURST) queue_item(12'd0, 1'b0);
        // full-scale burst, last axis vertical
        queue_item(12'd0, 1'b0);
        repeat (SAMPLES_PER_BURST - 1) queue_item(12'd4095, 1'b0);
        queue_item(12'd4095, 1'b1);
        // repeated extremes and axis flips inside the burst
        queue_item(12'd77, 1'b0);
        queue_item(12'd1000, 1'b1);
        queue_item(12'd4095, 1'b0);
        queue_item(12'd0, 1'b1);
        queue_item(12'd4095, 1'b0);
        queue_item(12'd0, 1'b1);
        queue_item(12'd1000, 1'b0);
        settle();

        set_zones(ZONE_FLOOR_RST, ZONE_EDGE_ONE_RST, ZONE_EDGE_TWO_RST, ZONE_CEILING_RST);
        run_phase(0);
        settle();
        set_zones(12'd0, 12'd0, 12'd0, 12'd0);
        run_phase(15);
        settle();
        set_zones(12'd4095, 12'd4095, 12'd4095, 12'd4095);
        run_phase(30);
        settle();
        set_zones(12'd0, 12'd4095, 12'd4095, 12'd4095);
        run_phase(10);
        hold_requests++;
        settle();
        set_zones(12'd0, 12'd0, 12'd0, 12'd4095);
        run_phase(0);
        settle();
        a = CFG_W'($urandom_range(1000));
        b = a + CFG_W'($urandom_range(1000));
        c = b + CFG_W'($urandom_range(1000));
        set_zones(a, b, c, c + CFG_W'($urandom_range(1000)));
        run_phase(20);
        hold_requests++;
        settle();
        set_zones(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
        run_phase(30);
        settle();
        set_zones(12'd100, 12'd50, 12'd3000, 12'd2000);
        run_phase(15);
        settle();
        set_zones(ZONE_FLOOR_RST, ZONE_EDGE_ONE_RST, ZONE_EDGE_TWO_RST, ZONE_CEILING_RST);
        run_phase(0);
        settle();

        if (failures == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
